// ----- hdl/assert_macros.svh -----
// assertion helpers used by slip_deframer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define SD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be seen outside reset
`define SD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define SD_ASSERT(lbl, clk, rst_n, prop)
`define SD_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- hdl/sd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sd_pkg;

    // framing codes
    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam int MAX_FRAME_BYTES_DEF = 2048;
    localparam int CFG_W               = 12;
    localparam int INDEX_W             = 11;
    localparam int LENGTH_W            = 12;
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 12'd2048;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_FRAME  = 2'd1,
        MODE_ESCAPE = 2'd2,
        MODE_HUNT   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_REJECT   = 2'd2,
        KIND_ABORT    = 2'd3
    } t_kind;

    typedef struct packed {
        logic                has;
        t_kind               kind;
        logic [7:0]          payload;
        logic [INDEX_W-1:0]  index;
        logic [LENGTH_W-1:0] length;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/sd_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

// received byte channel
interface sd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// decoded result channel
interface sd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [10:0] byte_index;
    logic [11:0] frame_length;

    modport source (output valid, output kind, output payload_byte, output byte_index,
                    output frame_length, input ready);
    modport sink   (input valid, input kind, input payload_byte, input byte_index,
                    input frame_length, output ready);
endinterface

// limit register write channel
interface sd_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] max_frame_length;

    modport source (output valid, output max_frame_length, input ready);
    modport sink   (input valid, input max_frame_length, output ready);
endinterface

`default_nettype wire

// ----- hdl/sd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sd_decode
    import sd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int CNT_W           = 12
) (
    input  wire t_mode              i_mode,
    input  wire logic [CNT_W-1:0]   i_count,
    input  wire logic [7:0]         i_byte,
    input  wire logic [CFG_W-1:0]   i_max_len,
    output t_mode                   o_mode,
    output logic [CNT_W-1:0]        o_count,
    output t_result                 o_result
);

    logic       room;
    logic       esc_ok;
    logic [7:0] literal;

    // room left under both the register and the build-time limit
    assign room = (CFG_W'(i_count) < i_max_len) &&
                  (32'(i_count) < 32'(MAX_FRAME_BYTES));

    assign esc_ok = (i_byte == SLIP_ESC_END) || (i_byte == SLIP_ESC_ESC);

    always_comb begin
        if (i_mode == MODE_ESCAPE) begin
            literal = (i_byte == SLIP_ESC_END) ? SLIP_END : SLIP_ESC;
        end else begin
            literal = i_byte;
        end
    end

    // next state
    always_comb begin
        o_mode  = i_mode;
        o_count = i_count;
        unique case (i_mode) inside
            MODE_WAIT, MODE_FRAME: begin
                if (i_byte == SLIP_END) begin
                    if (i_mode == MODE_WAIT) begin
                        o_mode = MODE_FRAME;
                    end else begin
                        o_mode  = MODE_WAIT;
                        o_count = '0;
                    end
                end else if (i_byte == SLIP_ESC) begin
                    o_mode = MODE_ESCAPE;
                end else if (room) begin
                    o_mode  = MODE_FRAME;
                    o_count = i_count + CNT_W'(1);
                end else begin
                    o_mode = MODE_HUNT;
                end
            end
            MODE_ESCAPE: begin
                if (esc_ok && room) begin
                    o_mode  = MODE_FRAME;
                    o_count = i_count + CNT_W'(1);
                end else begin
                    o_mode = MODE_HUNT;
                end
            end
            MODE_HUNT: begin
                if (i_byte == SLIP_END) begin
                    o_mode  = MODE_WAIT;
                    o_count = '0;
                end
            end
            default: begin
                o_mode = MODE_WAIT;
            end
        endcase
    end

    // result
    always_comb begin
        o_result         = '0;
        o_result.kind    = KIND_BYTE;
        unique case (i_mode) inside
            MODE_WAIT, MODE_FRAME: begin
                if (i_byte == SLIP_END) begin
                    if (i_mode == MODE_FRAME && i_count != '0) begin
                        o_result.has    = 1'b1;
                        o_result.kind   = (i_count[1:0] == 2'b00) ? KIND_COMPLETE
                                                                  : KIND_REJECT;
                        o_result.length = LENGTH_W'(i_count);
                    end
                end else if (i_byte != SLIP_ESC) begin
                    o_result.has = 1'b1;
                    if (room) begin
                        o_result.payload = literal;
                        o_result.index   = INDEX_W'(i_count);
                    end else begin
                        o_result.kind = KIND_ABORT;
                    end
                end
            end
            MODE_ESCAPE: begin
                o_result.has = 1'b1;
                if (esc_ok && room) begin
                    o_result.payload = literal;
                    o_result.index   = INDEX_W'(i_count);
                end else begin
                    o_result.kind = KIND_ABORT;
                end
            end
            default: begin
                o_result.has = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/slip_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// slip deframer: strips slip framing (end 0xc0, esc 0xdb, esc_end 0xdc, esc_esc 0xdd)
// from a byte stream and passes each decoded payload byte on at once with its position
// in the frame; an end closing a non-empty frame gives a frame result (complete when
// the length is a multiple of 4, rejected otherwise), a bad escape or a frame past the
// length limit gives an abort, after which bytes are dropped until the next end. one
// byte is taken every cycle while the result register is free; the transfer loads the
// input register, the decode between the input and result registers loads the result
// register, and a stalled result holds the input. the limit is the smaller of the
// max_frame_length register and MAX_FRAME_BYTES; write the register only while idle.
// downstream keeps or discards the streamed bytes according to the frame result.

`include "assert_macros.svh"

module slip_deframer
    import sd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sd_in_if.sink     i_in,
    sd_cfg_if.sink    i_cfg,
    sd_out_if.source  o_out
);

    // the count never passes the effective limit, which the 12-bit register caps
    localparam int CNT_MAX = (MAX_FRAME_BYTES < 4095) ? MAX_FRAME_BYTES : 4095;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    // decode state and limit register
    t_mode            r_mode;
    t_mode            n_mode;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CFG_W-1:0] r_max_len;

    // result register
    logic             r_out_valid;
    t_result          r_out;
    t_result          n_result;

    logic             out_free;
    logic             advance;

    // result register can take a new value this cycle
    assign out_free = !r_out_valid || o_out.ready;
    // byte in the input register is decoded and retired this cycle
    assign advance  = r_in_valid && out_free;

    assign i_in.ready  = !r_in_valid || out_free;
    assign i_cfg.ready = 1'b1;

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_max_len <= i_cfg.max_frame_length;
        end
    end

    // input register, refilled whenever it empties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
        end
    end

    sd_decode #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CNT_W           (CNT_W)
    ) u_decode (
        .i_mode    (r_mode),
        .i_count   (r_count),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_mode    (n_mode),
        .o_count   (n_count),
        .o_result  (n_result)
    );

    // decode state moves only when the byte retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_WAIT;
            r_count <= '0;
        end else if (advance) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    // result register; a byte with no result just empties it on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_result.has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_result.has) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.payload_byte = r_out.payload;
    assign o_out.byte_index   = r_out.index;
    assign o_out.frame_length = r_out.length;

    // waiting for a frame always starts from an empty count
    `SD_ASSERT(a_wait_empty, i_clk, i_rst_n, (r_mode == MODE_WAIT) |-> (r_count == '0))
    // count stays within the build-time limit
    `SD_NEVER(a_count_cap, i_clk, i_rst_n, 32'(r_count) > 32'(MAX_FRAME_BYTES))
    // a held abort leaves the decoder hunting for end
    `SD_ASSERT(a_abort_hunt, i_clk, i_rst_n,
               (r_out_valid && r_out.kind == KIND_ABORT) |-> (r_mode == MODE_HUNT))
    // a complete frame is non-empty and 4-byte aligned
    `SD_ASSERT(a_complete_len, i_clk, i_rst_n,
               (r_out_valid && r_out.kind == KIND_COMPLETE) |->
               (r_out.length[1:0] == 2'b00 && r_out.length != '0))
    // a stalled result freezes the decode state
    `SD_ASSERT(a_stall_hold, i_clk, i_rst_n,
               (r_out_valid && !o_out.ready) |=> ($stable(r_count) && $stable(r_mode)))

endmodule

`default_nettype wire
